// File: rtl/cbmt_pkg.sv
// Package for the counter bank with max tracking.
// Holds the sequencer state type, item mode and fault codes, and port field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbmt_pkg;

  // Port field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned POP_W   = 7;
  localparam int unsigned FAULT_W = 2;

  // Largest population the result port can show
  localparam logic [POP_W-1:0] POP_SAT = '1;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_INC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

  // Fault codes
  localparam logic [FAULT_W-1:0] FLT_OK   = 2'd0;
  localparam logic [FAULT_W-1:0] FLT_ZERO = 2'd1;
  localparam logic [FAULT_W-1:0] FLT_SAT  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } cbmt_state_t;

endpackage

`default_nettype wire

// File: rtl/counter_bank_max_tracker.sv
// Counter bank with max tracking: top level, sequencer and shared compare unit.
// Depends on cbmt_pkg and cbmt_ram.
//
// Usage
//   Input channel (in_valid/in_ready, in_mode, in_index): one beat names a
//   counter and asks to increment (saturating), decrement (refused at zero),
//   clear it, or only read it. An index at or beyond NUM_COUNTERS changes
//   nothing and returns value 0.
//   Result channel (out_valid/out_ready): one beat per input beat, in order,
//   carrying the counter's new value, the bank maximum, how many counters hold
//   it (saturated at 127) and a fault code.
// Timing
//   Counters live in a RAM with registered read. A normal item goes through
//   read, execute/write and result load. When the sole counter at the
//   maximum is lowered, the bank is rescanned through one shared comparator,
//   one RAM read per cycle. One item is in work at a time.
// Reset
//   After rst_n the sequencer sweeps the RAM writing zero, one counter per
//   cycle, with in_ready low. Max is then 0 with a
//   population of NUM_COUNTERS.
// Stall
//   The result sits in an output register; the next item is accepted and
//   worked on while it waits, and only the result load waits for out_ready.
`timescale 1ns / 1ps
`default_nettype none

module counter_bank_max_tracker
  import cbmt_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = 64,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [IDX_W-1:0]   in_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [VALUE_W-1:0]      out_value,
  output logic [VALUE_W-1:0]      out_max_value,
  output logic [POP_W-1:0]        out_max_population,
  output logic [FAULT_W-1:0]      out_fault
);

  localparam int unsigned AW  = $clog2(NUM_COUNTERS);
  localparam int unsigned PW  = $clog2(NUM_COUNTERS + 1);
  localparam int unsigned SCW = $clog2(NUM_COUNTERS + 1);
  localparam int unsigned XW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned CXW = (COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W;
  localparam int unsigned PXW = (PW > POP_W) ? PW : POP_W;
  localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(NUM_COUNTERS - 1);
  localparam logic [SCW-1:0] SCAN_END  = SCW'(NUM_COUNTERS);
  localparam logic [PW-1:0]  POP_INIT  = PW'(NUM_COUNTERS);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  cbmt_state_t          state_r,     state_nxt;
  logic [AW-1:0]        clr_addr_r,  clr_addr_nxt;
  logic [MODE_W-1:0]    mode_r,      mode_nxt;
  logic [AW-1:0]        addr_r,      addr_nxt;
  logic                 in_range_r,  in_range_nxt;
  logic [COUNT_BITS-1:0] val_r,      val_nxt;
  logic [FAULT_W-1:0]   fault_r,     fault_nxt;
  logic [COUNT_BITS-1:0] max_r,      max_nxt;
  logic [PW-1:0]        pop_r,       pop_nxt;
  logic [SCW-1:0]       scan_cnt_r,  scan_cnt_nxt;
  logic                 scan_dv_r,   scan_dv_nxt;
  logic                 scan_last_r, scan_last_nxt;
  logic [COUNT_BITS-1:0] scan_max_r, scan_max_nxt;
  logic [PW-1:0]        scan_pop_r,  scan_pop_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic [VALUE_W-1:0]   out_max_r,   out_max_nxt;
  logic [POP_W-1:0]     out_pop_r,   out_pop_nxt;
  logic [FAULT_W-1:0]   out_fault_r, out_fault_nxt;

  // RAM port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // Shared compare unit
  logic [COUNT_BITS-1:0] cmp_a, cmp_b;
  logic                  cmp_eq, cmp_gt;

  // Misc
  logic [XW-1:0]  idx_x;
  logic           idx_in_range;
  logic           in_fire;
  logic           out_free;
  logic [CXW-1:0] val_x;
  logic [CXW-1:0] max_x;
  logic [PXW-1:0] pop_x;

  cbmt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_COUNTERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign idx_x        = XW'(in_index);
  assign idx_in_range = (32'(in_index) < 32'(NUM_COUNTERS));
  assign in_ready     = (state_r == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;

  // One comparator: against the tracked max while executing, against the
  // running scan max while rescanning.
  always_comb begin
    if (state_r == ST_SCAN) begin
      cmp_a = ram_rdata;
      cmp_b = scan_max_r;
    end else begin
      cmp_a = ram_rdata;
      cmp_b = max_r;
    end
    cmp_eq = (cmp_a == cmp_b);
    cmp_gt = (cmp_a > cmp_b);
  end

  // Read address mux
  always_comb begin
    case (state_r)
      ST_IDLE: ram_raddr = idx_x[AW-1:0];
      ST_SCAN: ram_raddr = scan_cnt_r[AW-1:0];
      default: ram_raddr = addr_r;
    endcase
  end

  // Result formatting: narrow counters zero-extend, wide ones truncate
  assign val_x = CXW'(val_r);
  assign max_x = CXW'(max_r);
  assign pop_x = PXW'(pop_r);

  // ---------------------------------------------------------------------
  // Sequencer: next state and datapath
  // ---------------------------------------------------------------------
  always_comb begin
    logic [COUNT_BITS-1:0] c;
    logic lower;

    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    in_range_nxt  = in_range_r;
    val_nxt       = val_r;
    fault_nxt     = fault_r;
    max_nxt       = max_r;
    pop_nxt       = pop_r;
    scan_cnt_nxt  = scan_cnt_r;
    scan_dv_nxt   = 1'b0;
    scan_last_nxt = 1'b0;
    scan_max_nxt  = scan_max_r;
    scan_pop_nxt  = scan_pop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_max_nxt   = out_max_r;
    out_pop_nxt   = out_pop_r;
    out_fault_nxt = out_fault_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;
    c             = ram_rdata;
    lower         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt     = in_mode;
          addr_nxt     = idx_x[AW-1:0];
          in_range_nxt = idx_in_range;
          state_nxt    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        val_nxt   = c;
        fault_nxt = FLT_OK;
        state_nxt = ST_DONE;
        if (in_range_r) begin
          case (mode_r)
            MODE_INC: begin
              if (c == CNT_TOP) begin
                fault_nxt = FLT_SAT;
              end else begin
                val_nxt   = c + COUNT_BITS'(1);
                ram_we    = 1'b1;
                ram_wdata = c + COUNT_BITS'(1);
                if (cmp_eq) begin
                  max_nxt = c + COUNT_BITS'(1);
                  pop_nxt = PW'(1);
                end else if (c + COUNT_BITS'(1) == max_r) begin
                  pop_nxt = pop_r + PW'(1);
                end
              end
            end
            MODE_DEC: begin
              if (c == '0) begin
                fault_nxt = FLT_ZERO;
              end else begin
                val_nxt   = c - COUNT_BITS'(1);
                ram_we    = 1'b1;
                ram_wdata = c - COUNT_BITS'(1);
                lower     = 1'b1;
              end
            end
            MODE_CLR: begin
              if (c != '0) begin
                val_nxt   = '0;
                ram_we    = 1'b1;
                ram_wdata = '0;
                lower     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else begin
          val_nxt = '0;
        end

        // Lowering a counter at the max: drop the population, or rescan
        // when it was the only one there.
        if (lower && cmp_eq) begin
          if (pop_r > PW'(1)) begin
            pop_nxt = pop_r - PW'(1);
          end else begin
            state_nxt    = ST_SCAN;
            scan_cnt_nxt = '0;
            scan_max_nxt = '0;
            scan_pop_nxt = '0;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the RAM registers the data, and scan_dv_r marks it valid.
        if (scan_cnt_r != SCAN_END) begin
          scan_cnt_nxt  = scan_cnt_r + SCW'(1);
          scan_dv_nxt   = 1'b1;
          scan_last_nxt = (scan_cnt_r == SCAN_END - SCW'(1));
        end
        if (scan_dv_r) begin
          if (cmp_gt) begin
            scan_max_nxt = ram_rdata;
            scan_pop_nxt = PW'(1);
          end else if (cmp_eq) begin
            scan_pop_nxt = scan_pop_r + PW'(1);
          end
          if (scan_last_r) begin
            max_nxt   = scan_max_nxt;
            pop_nxt   = scan_pop_nxt;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = val_x[VALUE_W-1:0];
          out_max_nxt   = max_x[VALUE_W-1:0];
          out_pop_nxt   = (pop_x > PXW'(POP_SAT)) ? POP_SAT : pop_x[POP_W-1:0];
          out_fault_nxt = fault_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      max_r       <= '0;
      pop_r       <= POP_INIT;
      scan_dv_r   <= 1'b0;
      scan_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      max_r       <= max_nxt;
      pop_r       <= pop_nxt;
      scan_dv_r   <= scan_dv_nxt;
      scan_last_r <= scan_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    addr_r      <= addr_nxt;
    in_range_r  <= in_range_nxt;
    val_r       <= val_nxt;
    fault_r     <= fault_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    scan_max_r  <= scan_max_nxt;
    scan_pop_r  <= scan_pop_nxt;
    out_value_r <= out_value_nxt;
    out_max_r   <= out_max_nxt;
    out_pop_r   <= out_pop_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_max_value      = out_max_r;
  assign out_max_population = out_pop_r;
  assign out_fault          = out_fault_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pop_r != '0))
    else $error("max population is zero while idle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted item did not move to execute");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && (state_nxt == ST_SCAN) |-> (pop_r == PW'(1)))
    else $error("rescan started with more than one counter at max");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result load did not raise out_valid");

endmodule

`default_nettype wire

// File: rtl/cbmt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cbmt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
